@@ hw/rtl/lrs_pkg.sv @@
// shared types, codes and constants of the link reconnect supervisor
`timescale 1ns / 1ps

package lrs_pkg;

   // event codes of the input word
   typedef enum logic [2:0] {
      FUNC_TICK         = 3'd0,
      FUNC_RADIO_START  = 3'd1,
      FUNC_DISCONNECT   = 3'd2,
      FUNC_GOT_ADDRESS  = 3'd3,
      FUNC_REQ_STATION  = 3'd4,
      FUNC_REQ_PORTAL   = 3'd5,
      FUNC_REQ_STOP     = 3'd6
   } func_type;

   // radio actions of the result word
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_CONNECT = 3'd1,
      ACT_STATION = 3'd2,
      ACT_PORTAL  = 3'd3,
      ACT_OFF     = 3'd4
   } action_type;

   // held host request
   typedef enum logic [1:0] {
      PEND_NONE    = 2'd0,
      PEND_STATION = 2'd1,
      PEND_PORTAL  = 2'd2,
      PEND_STOP    = 2'd3
   } pend_type;

   // csr register indexes
   localparam logic [1:0] CSR_AUTH_FAIL_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_NEVER_CONN_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_PORTAL_IDLE_TIMEOUT = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // csr reset values
   localparam logic [7:0]  AUTH_FAIL_LIMIT_RST    = 8'd3;
   localparam logic [7:0]  NEVER_CONN_LIMIT_RST   = 8'd20;
   localparam logic [15:0] PORTAL_IDLE_TIMEOUT_RST = 16'd600;

   // disconnect reasons counted as authentication failures
   localparam logic [7:0] REASON_AUTH_A = 8'd14;
   localparam logic [7:0] REASON_AUTH_B = 8'd15;
   localparam logic [7:0] REASON_AUTH_C = 8'd202;
   localparam logic [7:0] REASON_AUTH_D = 8'd204;

   // reconnect backoff in seconds, indexed by failures minus one, capped
   localparam int BACKOFF_DEPTH = 7;
   localparam logic [5:0] BACKOFF_SECS [BACKOFF_DEPTH] = '{
      6'd1, 6'd2, 6'd4, 6'd8, 6'd15, 6'd30, 6'd60
   };

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] reason;
      logic       have_credentials;
      logic       portal_client_seen;
   } req_word_type;

   typedef struct packed {
      logic [2:0] action;
      logic       link_up;
      logic       portal_mode;
      logic       portal_sticky;
      logic       station_active;
      logic [7:0] fail_count;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  auth_fail_limit;
      logic [7:0]  never_conn_limit;
      logic [15:0] portal_idle_timeout;
   } csr_type;

   typedef struct packed {
      logic        station_on;
      logic        connected;
      logic        portal_on;
      logic        sticky;
      logic [7:0]  fail_total;
      logic [7:0]  auth_fail_total;
      logic        ever_linked;
      logic [5:0]  retry_countdown;
      logic [15:0] portal_idle_secs;
      logic        portal_wanted;
      logic        portal_wanted_sticky;
      pend_type    pending;
   } state_type;

endpackage

@@ hw/rtl/lrs_update.sv @@
// next-state and action logic for one event word
`timescale 1ns / 1ps

module lrs_update import lrs_pkg::*; (
   input  state_type    cur,
   input  req_word_type word,
   input  csr_type      csr,
   output state_type    nxt,
   output action_type   action
);

   function automatic state_type apply_stop(input state_type s);
      state_type r;
      r = s;
      r.station_on      = 1'b0;
      r.portal_wanted   = 1'b0;
      r.retry_countdown = '0;
      r.portal_on       = 1'b0;
      r.connected       = 1'b0;
      return r;
   endfunction

   function automatic state_type apply_station(input state_type s);
      state_type r;
      r = s;
      r.portal_on       = 1'b0;
      r.fail_total      = '0;
      r.auth_fail_total = '0;
      r.retry_countdown = '0;
      r.portal_wanted   = 1'b0;
      r.station_on      = 1'b1;
      return r;
   endfunction

   function automatic state_type apply_portal(input state_type s, input logic stk);
      state_type r;
      r = s;
      r.portal_wanted = 1'b0;
      if (s.portal_on) begin
         r.sticky = s.sticky | stk;
      end else begin
         r.station_on       = 1'b0;
         r.retry_countdown  = '0;
         r.portal_idle_secs = '0;
         r.sticky           = stk;
         r.connected        = 1'b0;
         r.portal_on        = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [5:0] backoff(input logic [7:0] fails);
      logic [7:0] idx;
      idx = (fails > 8'd0) ? fails - 8'd1 : 8'd0;
      if (idx > 8'(BACKOFF_DEPTH - 1)) begin
         idx = 8'(BACKOFF_DEPTH - 1);
      end
      return BACKOFF_SECS[idx[2:0]];
   endfunction

   logic is_auth;
   logic [15:0] idle_inc;

   assign is_auth = (word.reason == REASON_AUTH_A) || (word.reason == REASON_AUTH_B) ||
                    (word.reason == REASON_AUTH_C) || (word.reason == REASON_AUTH_D);
   assign idle_inc = (cur.portal_idle_secs != 16'hFFFF) ? cur.portal_idle_secs + 16'd1
                                                         : cur.portal_idle_secs;

   always_comb begin
      nxt    = cur;
      action = ACT_NONE;
      unique case (func_type'(word.func))
         FUNC_TICK: begin
            if (cur.pending != PEND_NONE) begin
               nxt.pending = PEND_NONE;
               unique case (cur.pending)
                  PEND_STATION: begin
                     if (word.have_credentials) begin
                        nxt    = apply_station(nxt);
                        action = ACT_STATION;
                     end else begin
                        nxt    = apply_stop(nxt);
                        action = ACT_OFF;
                     end
                  end
                  PEND_PORTAL: begin
                     action = cur.portal_on ? ACT_NONE : ACT_PORTAL;
                     nxt    = apply_portal(nxt, 1'b1);
                  end
                  default: begin
                     nxt    = apply_stop(nxt);
                     action = ACT_OFF;
                  end
               endcase
            end else if (cur.portal_on) begin
               // unused timed portal counts idle seconds
               if (!(cur.sticky || word.portal_client_seen)) begin
                  nxt.portal_idle_secs = idle_inc;
                  if (idle_inc >= csr.portal_idle_timeout) begin
                     if (word.have_credentials) begin
                        nxt    = apply_station(nxt);
                        action = ACT_STATION;
                     end else begin
                        nxt    = apply_stop(nxt);
                        action = ACT_OFF;
                     end
                  end
               end
            end else if (cur.portal_wanted) begin
               nxt    = apply_portal(nxt, cur.portal_wanted_sticky);
               action = ACT_PORTAL;
            end else if (cur.retry_countdown != '0) begin
               nxt.retry_countdown = cur.retry_countdown - 6'd1;
               if (cur.retry_countdown == 6'd1) begin
                  action = ACT_CONNECT;
               end
            end
         end
         FUNC_RADIO_START: begin
            if (cur.station_on) begin
               action = ACT_CONNECT;
            end
         end
         FUNC_DISCONNECT: begin
            nxt.connected = 1'b0;
            if (cur.station_on) begin
               if (cur.fail_total != 8'hFF) begin
                  nxt.fail_total = cur.fail_total + 8'd1;
               end
               if (is_auth && (cur.auth_fail_total != 8'hFF)) begin
                  nxt.auth_fail_total = cur.auth_fail_total + 8'd1;
               end
               if (nxt.auth_fail_total >= csr.auth_fail_limit) begin
                  nxt.station_on           = 1'b0;
                  nxt.portal_wanted        = 1'b1;
                  nxt.portal_wanted_sticky = 1'b1;
               end else if (!cur.ever_linked && (nxt.fail_total >= csr.never_conn_limit)) begin
                  nxt.station_on           = 1'b0;
                  nxt.portal_wanted        = 1'b1;
                  nxt.portal_wanted_sticky = 1'b0;
               end else begin
                  nxt.retry_countdown = backoff(nxt.fail_total);
               end
            end
         end
         FUNC_GOT_ADDRESS: begin
            nxt.connected       = 1'b1;
            nxt.fail_total      = '0;
            nxt.auth_fail_total = '0;
            nxt.retry_countdown = '0;
            nxt.ever_linked     = 1'b1;
         end
         FUNC_REQ_STATION: nxt.pending = PEND_STATION;
         FUNC_REQ_PORTAL:  nxt.pending = PEND_PORTAL;
         FUNC_REQ_STOP:    nxt.pending = PEND_STOP;
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/link_reconnect_supervisor_unit.sv @@
// top level of the link reconnect supervisor
`timescale 1ns / 1ps

// link reconnect supervisor: takes one event word per cycle (tick, radio
// started, disconnect with reason, got address, or a host request) and gives
// one result word per event with the radio action and link status. an event
// word is held in an input register, the supervisor state is updated from it
// and the result lands in an output register, and a word can be taken every
// cycle while the result side keeps up. when the result side stalls, one more
// event waits in the input register before req_stall rises. host requests are
// only recorded and take effect at the next tick. the csr port is a plain
// write port (0 auth fail limit, 1 never-connected fail limit, 2 portal idle
// timeout); write it only while no event is in flight.

module link_reconnect_supervisor_unit import lrs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_word_type            req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_word_type            rsp_word,
   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // input register
   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type in_word_ff;
   logic         in_take;

   // output register
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_word_type out_word_ff;

   // supervisor state and csrs
   state_type    state_ff;
   state_type    state_in;
   csr_type      csr_ff;
   csr_type      csr_in;
   action_type   action;
   logic         advance;

   // the held word moves on when the output register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_take   = req_valid && !req_stall;

   assign in_valid_in  = in_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   lrs_update u_update (
      .cur    (state_ff),
      .word   (in_word_ff),
      .csr    (csr_ff),
      .nxt    (state_in),
      .action (action)
   );

   // csr writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_AUTH_FAIL_LIMIT:     csr_in.auth_fail_limit     = csr_wdata[7:0];
            CSR_NEVER_CONN_LIMIT:    csr_in.never_conn_limit    = csr_wdata[7:0];
            CSR_PORTAL_IDLE_TIMEOUT: csr_in.portal_idle_timeout = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{pending: PEND_NONE, default: '0};
         csr_ff       <= '{auth_fail_limit:     AUTH_FAIL_LIMIT_RST,
                           never_conn_limit:    NEVER_CONN_LIMIT_RST,
                           portal_idle_timeout: PORTAL_IDLE_TIMEOUT_RST};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         csr_ff       <= csr_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff.action         <= action;
         out_word_ff.link_up        <= state_in.connected;
         out_word_ff.portal_mode    <= state_in.portal_on;
         out_word_ff.portal_sticky  <= state_in.portal_on & state_in.sticky;
         out_word_ff.station_active <= state_in.station_on;
         out_word_ff.fail_count     <= state_in.fail_total;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
